// ===== rtl/tlt3_pkg.sv =====
// ----------------------------------------------------------------------------
// tlt3_pkg: shared constants for the three-axis trapezoidal trajectory core
// Fixed-point format, register map, phase codes and divider sizing.
// ----------------------------------------------------------------------------
package tlt3_pkg;

  // Q16.16 data format
  localparam int DW  = 32;
  localparam int FB  = 16;
  localparam int NAX = 3;

  // Divider: numerator is |end - start| shifted left by 2*FB
  localparam int NUM_W = DW + 1 + DW;
  localparam int DEN_W = 2 * DW;
  localparam int Q_W   = DW - 1;

  // Register map (word index)
  localparam logic [2:0] REG_TOTAL   = 3'd0;
  localparam logic [2:0] REG_RAMP    = 3'd1;
  localparam logic [2:0] REG_START_X = 3'd2;
  localparam logic [2:0] REG_START_Y = 3'd3;
  localparam logic [2:0] REG_START_Z = 3'd4;
  localparam logic [2:0] REG_END_X   = 3'd5;
  localparam logic [2:0] REG_END_Y   = 3'd6;
  localparam logic [2:0] REG_END_Z   = 3'd7;

  // Profile phases
  localparam logic [1:0] PH_UP     = 2'd0;
  localparam logic [1:0] PH_CRUISE = 2'd1;
  localparam logic [1:0] PH_DOWN   = 2'd2;

  typedef logic signed [DW-1:0] sword_t;

endpackage

// ===== rtl/trapezoidal_linear_trajectory_3axis_core.sv =====
// ----------------------------------------------------------------------------
// trapezoidal_linear_trajectory_3axis_core
// Position, velocity and acceleration of a straight three-axis move under a
// trapezoidal velocity profile, one sample time per request, Q16.16.
// ----------------------------------------------------------------------------
// The core takes one sample time per cycle while in_tready is high and
// returns its result through a five-stage pipeline; a stall on the output holds
// the whole pipeline. The peak acceleration per axis is found by a
// restoring divider, one quotient bit per cycle, three axes side by side:
// after reset and after every register write the core goes through one
// multiply, 65 divide steps and one finish with in_tready low before it
// takes samples again. A ramp time of zero or above half the total time
// sets config_error and forces all motion fields to zero.
module trapezoidal_linear_trajectory_3axis_core (
  input  logic         clk,
  input  logic         rst_n,
  // sample request
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,    // [31:0] sample_time
  // result request
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z (32 each)
  output logic [287:0] out_tdata,
  output logic [2:0]   out_tuser,   // [1:0] phase, [2] config_error
  // register port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int DW    = tlt3_pkg::DW;
  localparam int FB    = tlt3_pkg::FB;
  localparam int NAX   = tlt3_pkg::NAX;
  localparam int NUM_W = tlt3_pkg::NUM_W;
  localparam int DEN_W = tlt3_pkg::DEN_W;
  localparam int Q_W   = tlt3_pkg::Q_W;
  localparam int M_W   = 2 * DW - FB;        // 48: |a| * k >> FB
  localparam int ML_W  = M_W / 2;            // 24
  localparam int P_W   = M_W + DW + 1;       // 81: m * k2
  localparam int PP_W  = ML_W + DW + 1;      // 57: partial product

  // divider sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  logic [DW-1:0]    total_r, ramp_r;
  tlt3_pkg::sword_t start_r [NAX];
  tlt3_pkg::sword_t end_r   [NAX];
  logic             cfg_wr;
  logic [2:0]       cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= 32'h0001_0000;
      ramp_r  <= 32'h0000_4000;
      for (int i = 0; i < NAX; i++) begin
        start_r[i] <= '0;
        end_r[i]   <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tlt3_pkg::REG_TOTAL:   total_r    <= cfg_pwdata;
        tlt3_pkg::REG_RAMP:    ramp_r     <= cfg_pwdata;
        tlt3_pkg::REG_START_X: start_r[0] <= cfg_pwdata;
        tlt3_pkg::REG_START_Y: start_r[1] <= cfg_pwdata;
        tlt3_pkg::REG_START_Z: start_r[2] <= cfg_pwdata;
        tlt3_pkg::REG_END_X:   end_r[0]   <= cfg_pwdata;
        tlt3_pkg::REG_END_Y:   end_r[1]   <= cfg_pwdata;
        tlt3_pkg::REG_END_Z:   end_r[2]   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // read back the addressed register
  always_comb begin
    unique case (cfg_idx)
      tlt3_pkg::REG_TOTAL:   cfg_prdata = total_r;
      tlt3_pkg::REG_RAMP:    cfg_prdata = ramp_r;
      tlt3_pkg::REG_START_X: cfg_prdata = start_r[0];
      tlt3_pkg::REG_START_Y: cfg_prdata = start_r[1];
      tlt3_pkg::REG_START_Z: cfg_prdata = start_r[2];
      tlt3_pkg::REG_END_X:   cfg_prdata = end_r[0];
      tlt3_pkg::REG_END_Y:   cfg_prdata = end_r[1];
      tlt3_pkg::REG_END_Z:   cfg_prdata = end_r[2];
      default:               cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Peak acceleration: R*(T-R), then a bit-serial divide per axis
  // --------------------------------------------------------------------------
  logic [1:0]       state_r, state_nxt;
  logic [6:0]       cnt_r;
  logic [DEN_W-1:0] den_r;
  logic [DW-1:0]    tmr_r;
  logic             cfg_err_r;
  logic [NUM_W-1:0] num_r [NAX];
  logic [NUM_W-1:0] rem_r [NAX];
  logic [Q_W-1:0]   q_r   [NAX];
  logic             ovf_r [NAX];
  logic             dn_r  [NAX];
  logic [DW-1:0]    am_r  [NAX];
  logic             an_r  [NAX];
  tlt3_pkg::sword_t a_r   [NAX];

  // sequence: multiply, divide steps, finish; restart on any write
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: state_nxt = ST_IDLE;
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  state_nxt = (cnt_r == '0) ? ST_FIN : ST_DIV;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_wr) state_nxt = ST_MUL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_MUL;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_MUL) cnt_r <= 7'(NUM_W - 1);
      else if (state_r == ST_DIV) cnt_r <= cnt_r - 7'd1;
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    logic signed [DW:0] d;
    logic [DW:0]        dm;
    logic [NUM_W-1:0]   rs;
    logic               ge;
    logic [DW-1:0]      am;
    if (state_r == ST_MUL) begin
      tmr_r     <= total_r - ramp_r;
      den_r     <= DEN_W'(ramp_r) * DEN_W'(total_r - ramp_r);
      cfg_err_r <= (ramp_r == '0) || ({ramp_r, 1'b0} > {1'b0, total_r});
    end
    for (int i = 0; i < NAX; i++) begin
      d  = (DW+1)'(end_r[i]) - (DW+1)'(start_r[i]);
      dm = d[DW] ? (DW+1)'(-d) : (DW+1)'(d);
      rs = {rem_r[i][NUM_W-2:0], num_r[i][NUM_W-1]};
      ge = rs >= {1'b0, den_r};
      am = ovf_r[i] ? (dn_r[i] ? 32'h8000_0000 : 32'h7fff_ffff) : {1'b0, q_r[i]};
      unique case (state_r)
        ST_MUL: begin
          dn_r[i]  <= d[DW];
          num_r[i] <= {dm, {DW{1'b0}}};
          rem_r[i] <= '0;
          q_r[i]   <= '0;
          ovf_r[i] <= 1'b0;
        end
        ST_DIV: begin
          rem_r[i] <= ge ? rs - {1'b0, den_r} : rs;
          num_r[i] <= {num_r[i][NUM_W-2:0], 1'b0};
          q_r[i]   <= {q_r[i][Q_W-2:0], ge};
          ovf_r[i] <= ovf_r[i] | q_r[i][Q_W-1];
        end
        ST_FIN: begin
          am_r[i] <= am;
          an_r[i] <= dn_r[i] && (am != '0);
          a_r[i]  <= (dn_r[i] && (am != '0)) ? -am : am;
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sample pipeline
  // --------------------------------------------------------------------------
  logic en;
  logic out_tvalid_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en && (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;

  // stage 1: phase and time offsets
  logic          v1_r, un1_r;
  logic [1:0]    ph1_r;
  logic [DW-1:0] t1_r, um1_r;
  logic [DW:0]   tw1_r;

  // stage 2: gain multiply
  logic             v2_r;
  logic [1:0]       ph2_r;
  logic [DW:0]      k2_2_r;
  logic [2*DW-1:0]  prod2_r [NAX];
  tlt3_pkg::sword_t acc2_r  [NAX];
  logic             vneg2_r [NAX];
  logic             pneg2_r [NAX];

  // stage 3: velocity and position partial products
  logic             v3_r;
  logic [1:0]       ph3_r;
  tlt3_pkg::sword_t vel3_r  [NAX];
  tlt3_pkg::sword_t acc3_r  [NAX];
  logic [PP_W-1:0]  ppl3_r  [NAX];
  logic [PP_W-1:0]  pph3_r  [NAX];
  logic             pneg3_r [NAX];

  // stage 4: position term
  logic             v4_r;
  logic [1:0]       ph4_r;
  tlt3_pkg::sword_t vel4_r  [NAX];
  tlt3_pkg::sword_t acc4_r  [NAX];
  logic [DW+1:0]    term4_r [NAX];
  logic             pneg4_r [NAX];

  // stage 5: output register
  tlt3_pkg::sword_t pos5_r [NAX];
  tlt3_pkg::sword_t vel5_r [NAX];
  tlt3_pkg::sword_t acc5_r [NAX];
  logic [1:0]       ph5_r;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid && in_tready;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      out_tvalid_r <= v4_r;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    logic [DW-1:0]          t;
    logic [DW-1:0]          k1;
    logic [M_W-1:0]         m;
    logic [P_W-1:0]         p;
    logic signed [DW+3:0]   sum;
    logic signed [DW+3:0]   tv;
    if (en) begin
      // phase select against ramp and total minus ramp
      t      = in_tdata;
      t1_r   <= t;
      ph1_r  <= (t <= ramp_r) ? tlt3_pkg::PH_UP :
                (t <= tmr_r) ? tlt3_pkg::PH_CRUISE : tlt3_pkg::PH_DOWN;
      un1_r  <= t > total_r;
      um1_r  <= (t > total_r) ? t - total_r : total_r - t;
      tw1_r  <= {t, 1'b0} - {1'b0, ramp_r};

      // pick multiplicands, multiply by |a|
      ph2_r <= ph1_r;
      case (ph1_r)
        tlt3_pkg::PH_UP:     begin k1 = t1_r;   k2_2_r <= {1'b0, t1_r};  end
        tlt3_pkg::PH_CRUISE: begin k1 = ramp_r; k2_2_r <= tw1_r;         end
        default:             begin k1 = um1_r;  k2_2_r <= {1'b0, um1_r}; end
      endcase
      for (int i = 0; i < NAX; i++) begin
        prod2_r[i] <= (2*DW)'(am_r[i]) * (2*DW)'(k1);
        vneg2_r[i] <= an_r[i] ^ ((ph1_r == tlt3_pkg::PH_DOWN) && un1_r);
        pneg2_r[i] <= an_r[i] ^ (ph1_r == tlt3_pkg::PH_DOWN);
        case (ph1_r)
          tlt3_pkg::PH_UP:     acc2_r[i] <= a_r[i];
          tlt3_pkg::PH_CRUISE: acc2_r[i] <= '0;
          default:             acc2_r[i] <= (a_r[i] == 32'sh8000_0000) ?
                                            32'sh7fff_ffff : -a_r[i];
        endcase
      end

      // saturate velocity, split position product
      ph3_r <= ph2_r;
      for (int i = 0; i < NAX; i++) begin
        m = prod2_r[i][2*DW-1:FB];
        if (m[M_W-1:DW-1] != '0)
          vel3_r[i] <= vneg2_r[i] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
          vel3_r[i] <= vneg2_r[i] ? -m[DW-1:0] : m[DW-1:0];
        acc3_r[i]  <= acc2_r[i];
        pneg3_r[i] <= pneg2_r[i];
        ppl3_r[i]  <= PP_W'(m[ML_W-1:0]) * PP_W'(k2_2_r);
        pph3_r[i]  <= PP_W'(m[M_W-1:ML_W]) * PP_W'(k2_2_r);
      end

      // sum partials, shift and cap the position term
      ph4_r <= ph3_r;
      for (int i = 0; i < NAX; i++) begin
        p = P_W'(ppl3_r[i]) + (P_W'(pph3_r[i]) << ML_W);
        if (p[P_W-1:DW+FB+2] != '0) term4_r[i] <= (DW+2)'(1) << (DW+1);
        else term4_r[i] <= {1'b0, p[DW+FB+1:FB+1]};
        vel4_r[i]  <= vel3_r[i];
        acc4_r[i]  <= acc3_r[i];
        pneg4_r[i] <= pneg3_r[i];
      end

      // add to start or end point, saturate
      ph5_r <= ph4_r;
      for (int i = 0; i < NAX; i++) begin
        tv  = (DW+4)'(term4_r[i]);
        sum = (ph4_r == tlt3_pkg::PH_DOWN) ? (DW+4)'(end_r[i]) : (DW+4)'(start_r[i]);
        sum = pneg4_r[i] ? sum - tv : sum + tv;
        if (sum > (DW+4)'(32'sh7fff_ffff))       pos5_r[i] <= 32'sh7fff_ffff;
        else if (sum < (DW+4)'(32'sh8000_0000))  pos5_r[i] <= 32'sh8000_0000;
        else                                     pos5_r[i] <= sum[DW-1:0];
        vel5_r[i] <= vel4_r[i];
        acc5_r[i] <= acc4_r[i];
      end
    end
  end

  // drop motion fields on a bad ramp time
  always_comb begin
    out_tdata = '0;
    out_tuser = {1'b1, tlt3_pkg::PH_UP};
    if (!cfg_err_r) begin
      for (int i = 0; i < NAX; i++) begin
        out_tdata[DW*i +: DW]         = pos5_r[i];
        out_tdata[DW*(NAX+i) +: DW]   = vel5_r[i];
        out_tdata[DW*(2*NAX+i) +: DW] = acc5_r[i];
      end
      out_tuser = {1'b0, ph5_r};
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("sample taken during recompute");

  a_wr_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (state_r == ST_MUL)) else $error("write did not restart divider");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2]) |-> (out_tdata == '0 && out_tuser[1:0] == tlt3_pkg::PH_UP))
    else $error("motion fields not cleared on bad ramp");

  a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[1:0] != 2'd3)) else $error("bad phase code");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && out_tvalid && !out_tready) |=> v4_r) else $error("pipeline lost a request");

endmodule

// ===== verif/trajectory_checker.sv =====
// ----------------------------------------------------------------------------
// trajectory_checker: result predictor and scoreboard for the trajectory core
// Mirrors register writes seen on the APB port, predicts the motion fields
// for every accepted sample request and compares each result request in order.
// ----------------------------------------------------------------------------
module trajectory_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [31:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [287:0] out_tdata,
  input  logic [2:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [8:0][31:0] motion;  // pos x,y,z, vel x,y,z, acc x,y,z
    logic [1:0]       phase;
    logic             cfg_err;
  } motion_t;

  logic [31:0] total_r, ramp_r;
  logic [2:0][31:0] start_r, end_r;
  motion_t expected_motion[$];

  string field_name[9] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                           "acc_x", "acc_y", "acc_z"};

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic motion_t predict_motion(logic [31:0] t);
    motion_t r;
    logic [127:0] num, den, q, m, mc, p;
    logic [63:0] am, k, um, vm, term;
    longint d, a, s_term;
    logic an, un;
    logic [1:0] ph;
    r = '0;
    if (ramp_r == 0 || {ramp_r, 1'b0} > {1'b0, total_r}) begin
      r.cfg_err = 1'b1;
      return r;
    end
    ph = (t <= ramp_r) ? tlt3_pkg::PH_UP :
         ((t <= total_r - ramp_r) ? tlt3_pkg::PH_CRUISE : tlt3_pkg::PH_DOWN);
    un = t > total_r;
    um = un ? 64'(t - total_r) : 64'(total_r - t);
    for (int ax = 0; ax < tlt3_pkg::NAX; ax++) begin
      d = longint'($signed(end_r[ax])) - longint'($signed(start_r[ax]));
      num = 128'(d < 0 ? -d : d) << 32;
      den = 128'(ramp_r) * 128'(total_r - ramp_r);
      q = num / den;
      if (q > 128'(1) << 33) q = 128'(1) << 33;
      a = (d < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
      a = longint'($signed(clamp32(a)));
      an = a < 0;
      am = an ? 64'(-a) : 64'(a);
      case (ph)
        tlt3_pkg::PH_UP: begin m = (128'(am) * 128'(t)) >> 16; k = 64'(t); end
        tlt3_pkg::PH_CRUISE: begin
          m = (128'(am) * 128'(ramp_r)) >> 16;
          k = 64'(t) * 2 - 64'(ramp_r);
        end
        default: begin m = (128'(am) * 128'(um)) >> 16; k = um; end
      endcase
      // velocity, with direction reversed once time runs past the end
      vm = (m > 128'(1) << 32) ? 64'(1) << 32 : m[63:0];
      r.motion[3+ax] = clamp32(((ph == tlt3_pkg::PH_DOWN) ? (an ^ un) : an) ?
                               -longint'(vm) : longint'(vm));
      // position term, limited so a saturating position stays saturated
      mc = (m >= 128'(1) << 49) ? 128'(1) << 49 : m;
      p = (mc * 128'(k)) >> 17;
      term = (p > 128'(1) << 33) ? 64'(1) << 33 : p[63:0];
      s_term = an ? -longint'(term) : longint'(term);
      if (ph == tlt3_pkg::PH_DOWN) begin
        r.motion[ax] = clamp32(longint'($signed(end_r[ax])) - s_term);
        r.motion[6+ax] = clamp32(-a);
      end else begin
        r.motion[ax] = clamp32(longint'($signed(start_r[ax])) + s_term);
        r.motion[6+ax] = (ph == tlt3_pkg::PH_UP) ? a[31:0] : 32'd0;
      end
    end
    r.phase = ph;
    return r;
  endfunction

  assign pending = expected_motion.size();

  always @(posedge clk) begin
    motion_t exp_m;
    int errs;
    if (!rst_n) begin
      total_r <= 32'd65536;
      ramp_r <= 32'd16384;
      start_r <= '0;
      end_r <= '0;
      fail_count <= 0;
      expected_motion.delete();
    end else begin
      errs = 0;
      // track register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          tlt3_pkg::REG_TOTAL:   total_r <= cfg_pwdata;
          tlt3_pkg::REG_RAMP:    ramp_r <= cfg_pwdata;
          tlt3_pkg::REG_START_X: start_r[0] <= cfg_pwdata;
          tlt3_pkg::REG_START_Y: start_r[1] <= cfg_pwdata;
          tlt3_pkg::REG_START_Z: start_r[2] <= cfg_pwdata;
          tlt3_pkg::REG_END_X:   end_r[0] <= cfg_pwdata;
          tlt3_pkg::REG_END_Y:   end_r[1] <= cfg_pwdata;
          default:               end_r[2] <= cfg_pwdata;
        endcase
      end
      if (in_tvalid && in_tready) expected_motion.push_back(predict_motion(in_tdata));
      // compare each result with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (expected_motion.size() == 0) begin
          $error("unexpected result request");
          errs++;
        end else begin
          exp_m = expected_motion.pop_front();
          for (int i = 0; i < 9; i++)
            if (out_tdata[32*i+:32] !== exp_m.motion[i]) begin
              $error("%s expected %h actual %h", field_name[i], exp_m.motion[i],
                     out_tdata[32*i+:32]);
              errs++;
            end
          if (out_tuser[1:0] !== exp_m.phase) begin
            $error("phase expected %0d actual %0d", exp_m.phase, out_tuser[1:0]);
            errs++;
          end
          if (out_tuser[2] !== exp_m.cfg_err) begin
            $error("config_error expected %0d actual %0d", exp_m.cfg_err, out_tuser[2]);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the three-axis trajectory core
// Walks the core through many register settings, valid and invalid, sends
// directed and random sample times with random gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;      // [31:0] sample_time
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [287:0] out_tdata;          // pos x,y,z, vel x,y,z, acc x,y,z
  logic [2:0]   out_tuser;          // [1:0] phase, [2] config_error
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [4:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;
  int           fail_count, pending;
  bit           calm = 1'b0;
  int           sample_count = 0, setting_count = 0;
  logic [31:0]  total_v = 32'd65536, ramp_v = 32'd16384;

  logic [31:0] rand_time_list[11] = '{32'd0, 32'd1, 32'h10000, 32'h10001, 32'h20000,
                                      32'h30000, 32'h30001, 32'h40000, 32'h40001,
                                      32'h7fffffff, 32'hffffffff};

  always #5 clk = ~clk;

  trapezoidal_linear_trajectory_3axis_core u_top (.*);

  trajectory_checker u_checker (.*);

  // draw a stall per result request
  initial begin
    int stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == tlt3_pkg::REG_TOTAL) total_v = val;
    if (idx == tlt3_pkg::REG_RAMP) ramp_v = val;
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic send_sample(logic [31:0] t);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= t;
    do @(posedge clk); while (!in_tready);
    sample_count++;
  endtask

  // write a full register set; hold off until the core is idle
  task automatic load_setting(logic [31:0] tot, logic [31:0] rmp,
                              logic [2:0][31:0] s, logic [2:0][31:0] e);
    in_tvalid <= 1'b0;
    drain();
    reg_write(tlt3_pkg::REG_TOTAL, tot);
    reg_write(tlt3_pkg::REG_RAMP, rmp);
    reg_write(tlt3_pkg::REG_START_X, s[0]);
    reg_write(tlt3_pkg::REG_START_Y, s[1]);
    reg_write(tlt3_pkg::REG_START_Z, s[2]);
    reg_write(tlt3_pkg::REG_END_X, e[0]);
    reg_write(tlt3_pkg::REG_END_Y, e[1]);
    reg_write(tlt3_pkg::REG_END_Z, e[2]);
    setting_count++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  // pick a sample time aimed at one part of the profile
  function automatic logic [31:0] rand_time();
    logic [31:0] edges[5];
    edges = '{ramp_v, ramp_v + 1, total_v - ramp_v, total_v - ramp_v + 1, total_v};
    if (ramp_v == 0 || 33'(ramp_v) * 2 > 33'(total_v)) return $urandom;
    case ($urandom_range(0, 6))
      0: return $urandom_range(0, ramp_v);
      1: return $urandom_range(ramp_v, total_v - ramp_v);
      2: return $urandom_range(total_v - ramp_v, total_v);
      3: return total_v + $urandom_range(0, 2 ** 18);
      4: return $urandom;
      default: return edges[$urandom_range(0, 4)];
    endcase
  endfunction

  initial begin
    logic [2:0][31:0] s, e;
    logic [31:0] tot, rmp;
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: null move
    send_sample(32'd0);
    send_sample(32'd40000);
    // extreme coordinates, ramp of one second over four
    s = '{32'd100, 32'd0, 32'h80000000};
    e = '{32'd100, 32'hfffb0000, 32'h7fffffff};
    load_setting(32'h40000, 32'h10000, s, e);
    foreach (rand_time_list[i]) send_sample(rand_time_list[i]);
    // equal halves: empty cruise
    load_setting(32'h20000, 32'h10000, e, s);
    send_sample(32'h10000);
    send_sample(32'h10001);
    send_sample(32'h20000);
    // zero ramp, then ramp above half the total
    load_setting(32'hffffffff, 32'd0, s, e);
    send_sample(32'd5);
    send_sample(32'hffffffff);
    load_setting(32'h20000, 32'h10001, s, e);
    send_sample(32'h8000);
    // longest move with an extreme ramp
    load_setting(32'hffffffff, 32'h7fffffff, s, e);
    send_sample(32'h7fffffff);
    send_sample(32'h80000000);
    send_sample(32'hffffffff);

    // random settings with random sample times
    for (int ph = 0; ph < 28; ph++) begin
      case ($urandom_range(0, 3))
        0: tot = $urandom;
        default: tot = $urandom_range(2 ** 12, 2 ** 20);
      endcase
      if ($urandom_range(0, 9) == 0) rmp = $urandom_range(0, 1) ? 32'd0 : tot / 2 + 1;
      else if ($urandom_range(0, 9) == 0) rmp = tot / 2;
      else rmp = $urandom_range(1, tot / 2);
      for (int ax = 0; ax < tlt3_pkg::NAX; ax++) begin
        s[ax] = rand_coord();
        e[ax] = rand_coord();
      end
      load_setting(tot, rmp, s, e);
      calm = (ph % 5 == 3);
      n = $urandom_range(40, 60);
      for (int i = 0; i < n; i++) begin
        // once let the core empty out before going on
        if (ph == 10 && i == n / 2) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_sample(rand_time());
      end
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;
    drain();
    $display("Sent %0d sample times across %0d register settings,", sample_count,
             setting_count);
    $display("covering ramp up, cruise, ramp down, overrun and bad-ramp cases.");
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
